// ----- rtl/core/software_timer_task_table_assert.svh -----
// ----------------------------------------------------------------------------
// software_timer_task_table_assert.svh
// Assertion macros used by the timer table datapath
// ----------------------------------------------------------------------------
`ifndef SOFTWARE_TIMER_TASK_TABLE_ASSERT_SVH
`define SOFTWARE_TIMER_TASK_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge out of reset
`define STTT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// condition must never be true out of reset
`define STTT_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error(msg);

`else

`define STTT_ASSERT(lbl, clk, rstn, prop, msg)
`define STTT_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// ----- rtl/core/sttt_pkg.sv -----
// ----------------------------------------------------------------------------
// sttt_pkg
// Operation and result codes, controller states and the command and status
// bundles between the timer table controller and datapath
// ----------------------------------------------------------------------------
package sttt_pkg;

    // operation codes of an input beat
    typedef enum logic [2:0] {
        OP_ADD        = 3'd0,
        OP_SET_ENABLE = 3'd1,
        OP_TICK       = 3'd2,
        OP_SERVICE    = 3'd3,
        OP_CLEAR      = 3'd4
    } op_t;

    // result kinds
    typedef enum logic [1:0] {
        KIND_ADDED = 2'd0,
        KIND_FULL  = 2'd1,
        KIND_FIRED = 2'd2,
        KIND_DONE  = 2'd3
    } kind_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;         // latch the input beat payload
        logic exec_single;  // run a one-step operation and emit its result
        op_t  op;           // operation being executed
        logic walk_start;   // rewind the slot walk
        logic walk_run;     // walk is active
        logic walk_svc;     // walk services slots, else it ticks them
        logic emit_done;    // emit the closing done result
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;     // output register can take a result this cycle
        logic walk_done;    // every slot has been visited
    } sts_t;

endpackage

// ----- rtl/core/sttt_ram.sv -----
// ----------------------------------------------------------------------------
// sttt_ram
// Generic single write port, single read port RAM with registered read data
// ----------------------------------------------------------------------------
module sttt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       aclk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds while rd_en is low
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/sttt_ctrl.sv -----
// ----------------------------------------------------------------------------
// sttt_ctrl
// Sequencer of the timer table: takes an input beat, runs one-step
// operations directly and steps the datapath through the slot walk of
// tick and service
// ----------------------------------------------------------------------------
module sttt_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [2:0]       s_operation,
    output sttt_pkg::cmd_t   cmd,
    input  sttt_pkg::sts_t   sts
);

    sttt_pkg::state_t state_reg, state_next;
    sttt_pkg::op_t    op_reg, op_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sttt_pkg::ST_IDLE;
            op_reg    <= sttt_pkg::OP_ADD;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        s_ready         = 1'b0;
        cmd             = '0;
        cmd.op          = op_reg;
        cmd.walk_svc    = (op_reg == sttt_pkg::OP_SERVICE);
        unique case (state_reg)
            sttt_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    op_next    = sttt_pkg::op_t'(s_operation);
                    state_next = sttt_pkg::ST_EXEC;
                end
            end
            sttt_pkg::ST_EXEC: begin
                unique case (op_reg) inside
                    sttt_pkg::OP_TICK, sttt_pkg::OP_SERVICE: begin
                        cmd.walk_start = 1'b1;
                        state_next     = sttt_pkg::ST_WALK;
                    end
                    default: begin
                        if (sts.out_free) begin
                            cmd.exec_single = 1'b1;
                            state_next      = sttt_pkg::ST_IDLE;
                        end
                    end
                endcase
            end
            sttt_pkg::ST_WALK: begin
                cmd.walk_run = 1'b1;
                if (sts.walk_done && sts.out_free) begin
                    cmd.emit_done = 1'b1;
                    state_next    = sttt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sttt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/sttt_dpath.sv -----
// ----------------------------------------------------------------------------
// sttt_dpath
// Timer table datapath: slot valid and enable flags, count and setup RAMs,
// the slot walk pointer with its one-stage read pipeline, and the result
// output register
// ----------------------------------------------------------------------------
`include "software_timer_task_table_assert.svh"

module sttt_dpath #(
    parameter int SLOT_COUNT  = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  sttt_pkg::cmd_t   cmd,
    output sttt_pkg::sts_t   sts,
    input  logic [3:0]       s_slot,
    input  logic             s_enable,
    input  logic [31:0]      s_delay,
    input  logic [31:0]      s_period,
    input  logic [7:0]       s_action_id,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_kind,
    output logic [3:0]       m_slot_index,
    output logic [7:0]       m_fired_action,
    output logic             m_last
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int PTR_W = $clog2(SLOT_COUNT + 1);
    localparam int CFG_W = COUNT_WIDTH + 8;
    localparam logic [PTR_W-1:0] PTR_END = PTR_W'(SLOT_COUNT);

    // latched payload
    logic [COUNT_WIDTH-1:0]  delay_reg, period_reg;
    logic [7:0]              action_reg;
    logic [3:0]              slot_reg;
    logic                    enable_reg;
    logic [COUNT_WIDTH+31:0] delay_ext, period_ext;

    // slot flags
    logic [SLOT_COUNT-1:0]   valid_reg, valid_next;
    logic [SLOT_COUNT-1:0]   en_reg, en_next;

    // free slot search and set_enable target
    logic                    free_found;
    logic [IDX_W-1:0]        free_idx;
    logic [IDX_W+3:0]        free_ext;
    logic [IDX_W+4:0]        slot_ext;
    logic                    slot_in_range;
    logic [IDX_W-1:0]        slot_sel;

    // walk
    logic [PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic                    ev_vld_reg, ev_vld_next;
    logic [IDX_W-1:0]        ev_idx_reg, ev_idx_next;
    logic [IDX_W+3:0]        ev_ext;
    logic [COUNT_WIDTH-1:0]  cnt_rd, period_rd;
    logic [CFG_W-1:0]        cfg_rd;
    logic [7:0]              action_rd;
    logic                    cnt_zero, ev_fire, advance, commit, issue;

    // ram ports
    logic                    cnt_we, cfg_we;
    logic [IDX_W-1:0]        cnt_waddr;
    logic [COUNT_WIDTH-1:0]  cnt_wdata;

    // output register
    logic                    m_valid_reg, emit;
    sttt_pkg::kind_t         out_kind_reg, emit_kind;
    logic [3:0]              out_idx_reg, emit_idx;
    logic [7:0]              out_action_reg, emit_action;
    logic                    out_last_reg, emit_last;

    // payload capture, delay and period cut or extended to count width
    assign delay_ext  = {{COUNT_WIDTH{1'b0}}, s_delay};
    assign period_ext = {{COUNT_WIDTH{1'b0}}, s_period};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            delay_reg  <= delay_ext[COUNT_WIDTH-1:0];
            period_reg <= period_ext[COUNT_WIDTH-1:0];
            action_reg <= s_action_id;
            slot_reg   <= s_slot;
            enable_reg <= s_enable;
        end
    end

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign free_ext      = {4'b0000, free_idx};
    assign slot_ext      = {{(IDX_W + 1){1'b0}}, slot_reg};
    assign slot_in_range = (slot_ext < (IDX_W + 5)'(SLOT_COUNT));
    assign slot_sel      = slot_ext[IDX_W-1:0];

    // slot stores
    sttt_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (SLOT_COUNT)
    ) u_cnt_ram (
        .aclk    (aclk),
        .wr_en   (cnt_we),
        .wr_addr (cnt_waddr),
        .wr_data (cnt_wdata),
        .rd_en   (issue),
        .rd_addr (rd_ptr_reg[IDX_W-1:0]),
        .rd_data (cnt_rd)
    );

    sttt_ram #(
        .WIDTH (CFG_W),
        .DEPTH (SLOT_COUNT)
    ) u_cfg_ram (
        .aclk    (aclk),
        .wr_en   (cfg_we),
        .wr_addr (free_idx),
        .wr_data ({period_reg, action_reg}),
        .rd_en   (issue),
        .rd_addr (rd_ptr_reg[IDX_W-1:0]),
        .rd_data (cfg_rd)
    );

    assign period_rd = cfg_rd[CFG_W-1:8];
    assign action_rd = cfg_rd[7:0];

    // evaluation of the slot whose data is out of the rams
    assign cnt_zero = (cnt_rd == '0);
    assign ev_fire  = cmd.walk_svc && ev_vld_reg && valid_reg[ev_idx_reg]
                      && (action_rd != 8'd0) && cnt_zero;
    assign advance  = !ev_vld_reg || !ev_fire || sts.out_free;
    assign commit   = cmd.walk_run && ev_vld_reg && advance;
    assign issue    = cmd.walk_run && advance && (rd_ptr_reg != PTR_END);
    assign ev_ext   = {4'b0000, ev_idx_reg};

    // walk pointer and read pipeline
    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        ev_vld_next = ev_vld_reg;
        ev_idx_next = ev_idx_reg;
        if (cmd.walk_start) begin
            rd_ptr_next = '0;
            ev_vld_next = 1'b0;
        end else if (cmd.walk_run && advance) begin
            ev_vld_next = issue;
            if (issue) begin
                rd_ptr_next = rd_ptr_reg + PTR_W'(1);
                ev_idx_next = rd_ptr_reg[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= PTR_END;
            ev_vld_reg <= 1'b0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            ev_vld_reg <= ev_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        ev_idx_reg <= ev_idx_next;
    end

    // count ram write: add, tick decrement or service reload
    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = ev_idx_reg;
        cnt_wdata = cnt_rd - COUNT_WIDTH'(1);
        if (cmd.exec_single && (cmd.op == sttt_pkg::OP_ADD) && free_found) begin
            cnt_we    = 1'b1;
            cnt_waddr = free_idx;
            cnt_wdata = delay_reg;
        end else if (commit) begin
            if (!cmd.walk_svc) begin
                cnt_we = valid_reg[ev_idx_reg] && en_reg[ev_idx_reg] && !cnt_zero;
            end else if (ev_fire && (period_rd != '0)) begin
                cnt_we    = 1'b1;
                cnt_wdata = period_rd;
            end
        end
    end

    assign cfg_we = cmd.exec_single && (cmd.op == sttt_pkg::OP_ADD) && free_found;

    // slot flag updates
    always_comb begin
        valid_next = valid_reg;
        en_next    = en_reg;
        if (cmd.exec_single) begin
            case (cmd.op)
                sttt_pkg::OP_ADD: begin
                    if (free_found) begin
                        valid_next[free_idx] = 1'b1;
                        en_next[free_idx]    = 1'b0;
                    end
                end
                sttt_pkg::OP_SET_ENABLE: begin
                    if (slot_in_range) begin
                        en_next[slot_sel] = enable_reg;
                    end
                end
                sttt_pkg::OP_CLEAR: begin
                    valid_next = '0;
                    en_next    = '0;
                end
                default: begin
                end
            endcase
        end
        // one-shot slot frees itself when it fires
        if (commit && ev_fire && (period_rd == '0)) begin
            valid_next[ev_idx_reg] = 1'b0;
            en_next[ev_idx_reg]    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            en_reg    <= '0;
        end else begin
            valid_reg <= valid_next;
            en_reg    <= en_next;
        end
    end

    // result selection
    always_comb begin
        emit        = 1'b0;
        emit_kind   = sttt_pkg::KIND_DONE;
        emit_idx    = 4'd0;
        emit_action = 8'd0;
        emit_last   = 1'b1;
        if (cmd.exec_single) begin
            emit = 1'b1;
            if (cmd.op == sttt_pkg::OP_ADD) begin
                if (free_found) begin
                    emit_kind = sttt_pkg::KIND_ADDED;
                    emit_idx  = free_ext[3:0];
                end else begin
                    emit_kind = sttt_pkg::KIND_FULL;
                end
            end
        end
        if (commit && ev_fire) begin
            emit        = 1'b1;
            emit_kind   = sttt_pkg::KIND_FIRED;
            emit_idx    = ev_ext[3:0];
            emit_action = action_rd;
            emit_last   = 1'b0;
        end
        if (cmd.emit_done) begin
            emit = 1'b1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= emit || (m_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_kind_reg   <= emit_kind;
            out_idx_reg    <= emit_idx;
            out_action_reg <= emit_action;
            out_last_reg   <= emit_last;
        end
    end

    assign sts.out_free  = !m_valid_reg || m_ready;
    assign sts.walk_done = (rd_ptr_reg == PTR_END) && !ev_vld_reg;

    assign m_valid        = m_valid_reg;
    assign m_kind         = out_kind_reg;
    assign m_slot_index   = out_idx_reg;
    assign m_fired_action = out_action_reg;
    assign m_last         = out_last_reg;

    // pipeline holds a slot only while a walk runs
    `STTT_ASSERT(a_ev_in_walk, aclk, aresetn, ev_vld_reg |-> cmd.walk_run, "slot in flight outside walk")
    // read pointer never passes the table end
    `STTT_ASSERT_NEVER(a_ptr_range, aclk, aresetn, rd_ptr_reg > PTR_END, "walk pointer past end")
    // a fired result carries a real action
    `STTT_ASSERT(a_fire_action, aclk, aresetn, (m_valid_reg && (out_kind_reg == sttt_pkg::KIND_FIRED)) |-> (out_action_reg != 8'd0), "fired result without action")
    // only fired results are non-final
    `STTT_ASSERT(a_last_kind, aclk, aresetn, (m_valid_reg && !out_last_reg) |-> (out_kind_reg == sttt_pkg::KIND_FIRED), "non-final result of wrong kind")

endmodule

// ----- rtl/core/software_timer_task_table.sv -----
// ----------------------------------------------------------------------------
// software_timer_task_table
// Table of SLOT_COUNT reloadable timer slots driven by add, set_enable, tick,
// service and clear beats
// ----------------------------------------------------------------------------
// One input beat is taken at a time. Add, set_enable, clear and undefined
// operations register their single result from the execute state once the
// output register is free, then the controller returns to idle. Tick and
// service walk the slots in ascending order, one slot per cycle through the
// read port of the count and setup RAMs while no fired result is held up.
// They register their closing done beat once every slot has been visited
// and the output register is free, then return to idle. A result that is due
// while the output register still holds an unaccepted beat stalls until the
// register is free. Service emits one fired beat per fired slot and a closing
// done beat with m_last set; every other operation emits one beat with m_last
// set. A new input beat is taken while the last result still waits in the
// output register. Slot numbers on m_slot_index keep their low four bits.
// ----------------------------------------------------------------------------
module software_timer_task_table #(
    parameter int SLOT_COUNT  = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [3:0]  s_slot,
    input  logic        s_enable,
    input  logic [31:0] s_delay,
    input  logic [31:0] s_period,
    input  logic [7:0]  s_action_id,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [3:0]  m_slot_index,
    output logic [7:0]  m_fired_action,
    output logic        m_last
);

    sttt_pkg::cmd_t cmd;
    sttt_pkg::sts_t sts;

    // sequencer
    sttt_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .cmd         (cmd),
        .sts         (sts)
    );

    // slot storage, walk and result register
    sttt_dpath #(
        .SLOT_COUNT  (SLOT_COUNT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_slot         (s_slot),
        .s_enable       (s_enable),
        .s_delay        (s_delay),
        .s_period       (s_period),
        .s_action_id    (s_action_id),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_slot_index   (m_slot_index),
        .m_fired_action (m_fired_action),
        .m_last         (m_last)
    );

endmodule
